/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

/* hdl/ipcs_pkg.sv */
// Package for the inverse Park/Clarke SPWM block: payload structs, state codes,
// register indexes and reset values. No dependencies.
`default_nettype none
package ipcs_pkg;

   localparam int ANGLE_STEPS   = 360;
   localparam int QUARTER_STEPS = 90;
   localparam int ANGLE_BITS    = 9;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PWM_GAIN   = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PWM_CENTER = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PWM_MIN    = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PWM_MAX    = 4'd3;

   localparam logic [15:0] PWM_GAIN_RESET   = 16'd500;
   localparam logic [15:0] PWM_CENTER_RESET = 16'd2048;
   localparam logic [15:0] PWM_MIN_RESET    = 16'd50;
   localparam logic [15:0] PWM_MAX_RESET    = 16'd4045;

   localparam logic [1:0] PHASE_U = 2'd0;
   localparam logic [1:0] PHASE_V = 2'd1;
   localparam logic [1:0] PHASE_W = 2'd2;

   typedef struct packed {
      logic signed [15:0] v_d;
      logic signed [15:0] v_q;
      logic signed [11:0] angle_deg;
   } req_type;

   typedef struct packed {
      logic [15:0] duty_u;
      logic [15:0] duty_v;
      logic [15:0] duty_w;
      logic [1:0]  peak_phase;
   } rsp_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] idx;
      logic                  cos_sel;
   } trig_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIN,
      ST_COS,
      ST_MUL_DC,
      ST_MUL_QS,
      ST_MUL_DS,
      ST_MUL_QC,
      ST_ADD_B,
      ST_MUL_KB,
      ST_PH_VW,
      ST_MUL_GV,
      ST_MUL_GW,
      ST_CMP_W,
      ST_PEAK
   } state_type;

endpackage
`default_nettype wire

/* hdl/inverse_park_clarke_spwm_top.sv */
// Inverse Park/Clarke transform with sinusoidal PWM compare generation.
// The sequencer steps through its states from ST_SIN to ST_PEAK between the input transfer and rsp_valid.
// All products go through one shared 18x32 signed multiplier stepped by the sequencer.
// The input stalls from its transfer until the result moves into the output register.
// Synchronous active-high reset: PWM registers take their reset values, peak phase is u.
// Depends on ipcs_pkg, ipcs_trig and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module inverse_park_clarke_spwm_top
   import ipcs_pkg::*;
#(
   parameter int COMPARE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]               csr_data
);

   localparam int PROD_BITS = 50;
   localparam int VAL_BITS  = 40;
   localparam int Q12_BITS  = 20;
   localparam logic signed [VAL_BITS-1:0] SAT_TOP =
      VAL_BITS'((64'd1 << COMPARE_BITS) - 64'd1);
   localparam logic signed [PROD_BITS-1:0] HALF30 = PROD_BITS'(64'd1 << 29);
   localparam logic signed [PROD_BITS-1:0] HALF12 = PROD_BITS'(64'd1 << 11);
   localparam logic signed [31:0] HALF14 = 32'sd8192;
   localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;

   function automatic logic [15:0] make_compare(
      input logic signed [PROD_BITS-1:0] p,
      input logic [15:0]                 center,
      input logic [15:0]                 lo,
      input logic [15:0]                 hi
   );
      logic signed [PROD_BITS-1:0] r;
      logic signed [VAL_BITS-1:0]  v;
      logic [VAL_BITS-1:0]         c;
      r = (p + HALF12) >>> 12;
      v = VAL_BITS'(r) + $signed({{(VAL_BITS-16){1'b0}}, center});
      if (v < 0) begin
         c = '0;
      end else if (v > SAT_TOP) begin
         c = SAT_TOP;
      end else begin
         c = v;
      end
      if (c > {{(VAL_BITS-16){1'b0}}, hi}) c = {{(VAL_BITS-16){1'b0}}, hi};
      if (c < {{(VAL_BITS-16){1'b0}}, lo}) c = {{(VAL_BITS-16){1'b0}}, lo};
      return c[15:0];
   endfunction

   state_type state_ff, state_in;

   logic [15:0] pwm_gain_ff, pwm_gain_in;
   logic [15:0] pwm_center_ff, pwm_center_in;
   logic [15:0] pwm_min_ff, pwm_min_in;
   logic [15:0] pwm_max_ff, pwm_max_in;
   logic [1:0]  last_peak_ff, last_peak_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic signed [15:0]          d_ff, d_in;
   logic signed [15:0]          q_ff, q_in;
   logic [ANGLE_BITS-1:0]       idx_ff, idx_in;
   logic signed [15:0]          s_ff, s_in;
   logic signed [15:0]          c_ff, c_in;
   logic signed [31:0]          alpha_ff, alpha_in;
   logic signed [31:0]          beta_ff, beta_in;
   logic signed [Q12_BITS-1:0]  q12u_ff, q12u_in;
   logic signed [Q12_BITS-1:0]  q12v_ff, q12v_in;
   logic signed [Q12_BITS-1:0]  q12w_ff, q12w_in;
   logic [15:0]                 duty_u_ff, duty_u_in;
   logic [15:0]                 duty_v_ff, duty_v_in;
   logic [15:0]                 duty_w_ff, duty_w_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;

   logic signed [17:0]          mul_a;
   logic signed [31:0]          mul_b;
   trig_req_type                trig_req;
   logic signed [15:0]          trig_val;

   logic                        req_xfer;
   logic                        rsp_load;
   logic [12:0]                 ang0, ang1, ang2, ang3, ang4;
   logic signed [PROD_BITS-1:0] alpha15, ph_v, ph_w;
   logic [15:0]                 best;
   logic [1:0]                  peak;

   ipcs_trig u_trig (
      .trig_req (trig_req),
      .trig_val (trig_val)
   );

   assign trig_req.idx     = idx_ff;
   assign trig_req.cos_sel = (state_ff == ST_COS);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_PEAK) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // angle mod 360 by restoring subtraction
   always_comb begin
      ang0 = 13'(req_data.angle_deg) + 13'(6 * ANGLE_STEPS);
      ang1 = (ang0 >= 13'(8 * ANGLE_STEPS)) ? 13'(ang0 - 13'(8 * ANGLE_STEPS)) : ang0;
      ang2 = (ang1 >= 13'(4 * ANGLE_STEPS)) ? 13'(ang1 - 13'(4 * ANGLE_STEPS)) : ang1;
      ang3 = (ang2 >= 13'(2 * ANGLE_STEPS)) ? 13'(ang2 - 13'(2 * ANGLE_STEPS)) : ang2;
      ang4 = (ang3 >= 13'(ANGLE_STEPS)) ? 13'(ang3 - 13'(ANGLE_STEPS)) : ang3;
   end

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_MUL_DC: begin
            mul_a = 18'(d_ff);
            mul_b = 32'(c_ff);
         end
         ST_MUL_QS: begin
            mul_a = 18'(q_ff);
            mul_b = 32'(s_ff);
         end
         ST_MUL_DS: begin
            mul_a = 18'(d_ff);
            mul_b = 32'(s_ff);
         end
         ST_MUL_QC: begin
            mul_a = 18'(q_ff);
            mul_b = 32'(c_ff);
         end
         ST_MUL_KB: begin
            mul_a = SQRT3_HALF_Q16;
            mul_b = beta_ff;
         end
         ST_PH_VW: begin
            mul_a = $signed({2'b00, pwm_gain_ff});
            mul_b = 32'(q12u_ff);
         end
         ST_MUL_GV: begin
            mul_a = $signed({2'b00, pwm_gain_ff});
            mul_b = 32'(q12v_ff);
         end
         ST_MUL_GW: begin
            mul_a = $signed({2'b00, pwm_gain_ff});
            mul_b = 32'(q12w_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      alpha15 = PROD_BITS'(alpha_ff) <<< 15;
      ph_v    = prod_ff - alpha15;
      ph_w    = -prod_ff - alpha15;

      peak = last_peak_ff;
      best = '0;
      if (duty_u_ff > best) begin
         best = duty_u_ff;
         peak = PHASE_U;
      end
      if (duty_v_ff > best) begin
         best = duty_v_ff;
         peak = PHASE_V;
      end
      if (duty_w_ff > best) begin
         peak = PHASE_W;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pwm_gain_in   = pwm_gain_ff;
      pwm_center_in = pwm_center_ff;
      pwm_min_in    = pwm_min_ff;
      pwm_max_in    = pwm_max_ff;
      last_peak_in  = last_peak_ff;
      rsp_in        = rsp_ff;
      d_in          = d_ff;
      q_in          = q_ff;
      idx_in        = idx_ff;
      s_in          = s_ff;
      c_in          = c_ff;
      alpha_in      = alpha_ff;
      beta_in       = beta_ff;
      q12u_in       = q12u_ff;
      q12v_in       = q12v_ff;
      q12w_in       = q12w_ff;
      duty_u_in     = duty_u_ff;
      duty_v_in     = duty_v_ff;
      duty_w_in     = duty_w_ff;
      prod_in       = mul_a * mul_b;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PWM_GAIN:   pwm_gain_in   = csr_data;
            CSR_PWM_CENTER: pwm_center_in = csr_data;
            CSR_PWM_MIN:    pwm_min_in    = csr_data;
            CSR_PWM_MAX:    pwm_max_in    = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               d_in     = req_data.v_d;
               q_in     = req_data.v_q;
               idx_in   = ang4[ANGLE_BITS-1:0];
               state_in = ST_SIN;
            end
         end
         ST_SIN: begin
            s_in     = trig_val;
            state_in = ST_COS;
         end
         ST_COS: begin
            c_in     = trig_val;
            state_in = ST_MUL_DC;
         end
         ST_MUL_DC: begin
            state_in = ST_MUL_QS;
         end
         ST_MUL_QS: begin
            alpha_in = 32'(prod_ff);
            state_in = ST_MUL_DS;
         end
         ST_MUL_DS: begin
            alpha_in = alpha_ff - 32'(prod_ff);
            state_in = ST_MUL_QC;
         end
         ST_MUL_QC: begin
            beta_in  = 32'(prod_ff);
            state_in = ST_ADD_B;
         end
         ST_ADD_B: begin
            beta_in  = beta_ff + 32'(prod_ff);
            q12u_in  = Q12_BITS'((alpha_ff + HALF14) >>> 14);
            state_in = ST_MUL_KB;
         end
         ST_MUL_KB: begin
            state_in = ST_PH_VW;
         end
         ST_PH_VW: begin
            q12v_in  = Q12_BITS'((ph_v + HALF30) >>> 30);
            q12w_in  = Q12_BITS'((ph_w + HALF30) >>> 30);
            state_in = ST_MUL_GV;
         end
         ST_MUL_GV: begin
            duty_u_in = make_compare(prod_ff, pwm_center_ff, pwm_min_ff, pwm_max_ff);
            state_in  = ST_MUL_GW;
         end
         ST_MUL_GW: begin
            duty_v_in = make_compare(prod_ff, pwm_center_ff, pwm_min_ff, pwm_max_ff);
            state_in  = ST_CMP_W;
         end
         ST_CMP_W: begin
            duty_w_in = make_compare(prod_ff, pwm_center_ff, pwm_min_ff, pwm_max_ff);
            state_in  = ST_PEAK;
         end
         ST_PEAK: begin
            if (rsp_load) begin
               rsp_in.duty_u     = duty_u_ff;
               rsp_in.duty_v     = duty_v_ff;
               rsp_in.duty_w     = duty_w_ff;
               rsp_in.peak_phase = peak;
               last_peak_in      = peak;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_gain_ff   <= PWM_GAIN_RESET;
         pwm_center_ff <= PWM_CENTER_RESET;
         pwm_min_ff    <= PWM_MIN_RESET;
         pwm_max_ff    <= PWM_MAX_RESET;
         last_peak_ff  <= PHASE_U;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pwm_gain_ff   <= pwm_gain_in;
         pwm_center_ff <= pwm_center_in;
         pwm_min_ff    <= pwm_min_in;
         pwm_max_ff    <= pwm_max_in;
         last_peak_ff  <= last_peak_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      d_ff      <= d_in;
      q_ff      <= q_in;
      idx_ff    <= idx_in;
      s_ff      <= s_in;
      c_ff      <= c_in;
      alpha_ff  <= alpha_in;
      beta_ff   <= beta_in;
      q12u_ff   <= q12u_in;
      q12v_ff   <= q12v_in;
      q12w_ff   <= q12w_in;
      duty_u_ff <= duty_u_in;
      duty_v_ff <= duty_v_in;
      duty_w_ff <= duty_w_in;
      prod_ff   <= prod_in;
   end

   `ASSERT_NEXT(a_xfer_starts_seq, clock, reset, req_xfer, state_ff == ST_SIN)
   `ASSERT_IMPLY(a_rsp_from_peak, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_PEAK))
   `ASSERT_IMPLY(a_peak_code, clock, reset, rsp_valid_ff,
      rsp_ff.peak_phase == PHASE_U || rsp_ff.peak_phase == PHASE_V ||
      rsp_ff.peak_phase == PHASE_W)
   `ASSERT_IMPLY(a_duty_in_range, clock, reset, rsp_valid_ff && (pwm_min_ff <= pwm_max_ff),
      rsp_ff.duty_u >= pwm_min_ff && rsp_ff.duty_u <= pwm_max_ff &&
      rsp_ff.duty_w >= pwm_min_ff && rsp_ff.duty_w <= pwm_max_ff)

endmodule
`default_nettype wire

/* hdl/ipcs_trig.sv */
// Sine/cosine lookup in Q1.14 for whole degrees 0..359, built from a
// quarter-wave constant table. Depends on ipcs_pkg.
`default_nettype none
module ipcs_trig
   import ipcs_pkg::*;
(
   input  trig_req_type       trig_req,
   output logic signed [15:0] trig_val
);

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // sin(k deg) in Q1.14, Taylor series in Q30, evaluated at elaboration
   function automatic logic [14:0] quarter_sine(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x    = (64'(k) * PI_Q30) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
      if (sum < 0) sum = '0;
      return 15'((unsigned'(sum) + 64'd32768) >> 16);
   endfunction

   logic [14:0] qsine_rom [0:QUARTER_STEPS];

   for (genvar k = 0; k <= QUARTER_STEPS; k++) begin : g_qsine
      localparam logic [14:0] QVAL = quarter_sine(k);
      assign qsine_rom[k] = QVAL;
   end

   logic [ANGLE_BITS:0]   m_sum;
   logic [ANGLE_BITS-1:0] m;
   logic [ANGLE_BITS-1:0] base;
   logic [1:0]            quad;
   logic [6:0]            r;
   logic [6:0]            addr;
   logic [14:0]           mag;

   always_comb begin
      m_sum = {1'b0, trig_req.idx} + (trig_req.cos_sel ? 10'(QUARTER_STEPS) : 10'd0);
      if (m_sum >= 10'(ANGLE_STEPS)) begin
         m = 9'(m_sum - 10'(ANGLE_STEPS));
      end else begin
         m = m_sum[ANGLE_BITS-1:0];
      end
      priority if (m >= 9'(3 * QUARTER_STEPS)) begin
         quad = 2'd3;
         base = 9'(3 * QUARTER_STEPS);
      end else if (m >= 9'(2 * QUARTER_STEPS)) begin
         quad = 2'd2;
         base = 9'(2 * QUARTER_STEPS);
      end else if (m >= 9'(QUARTER_STEPS)) begin
         quad = 2'd1;
         base = 9'(QUARTER_STEPS);
      end else begin
         quad = 2'd0;
         base = '0;
      end
      r    = 7'(m - base);
      addr = quad[0] ? 7'(7'(QUARTER_STEPS) - r) : r;
      mag  = qsine_rom[addr];
      if (quad[1]) begin
         trig_val = 16'(-$signed({1'b0, mag}));
      end else begin
         trig_val = $signed({1'b0, mag});
      end
   end

endmodule
`default_nettype wire

/* tb/tb_inverse_park_clarke_spwm_top.sv */
// Self-checking testbench for inverse_park_clarke_spwm_top: directed and random
// d/q/angle transfers under several PWM register settings, checked against a local model.
// Depends on ipcs_pkg and the RTL of inverse_park_clarke_spwm_top.
`default_nettype none
module tb_inverse_park_clarke_spwm_top;
   import ipcs_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int MAX_GAP = 8;
   localparam int SQRT3_HALF_Q16 = 56756;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 4'd9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   inverse_park_clarke_spwm_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model state
   logic signed [15:0] sine_tab [0:ANGLE_STEPS-1];
   logic [1:0] peak_seen = PHASE_U;
   int gain_cfg = int'(PWM_GAIN_RESET);
   int center_cfg = int'(PWM_CENTER_RESET);
   int min_cfg = int'(PWM_MIN_RESET);
   int max_cfg = int'(PWM_MAX_RESET);

   req_type req_pending [$];
   rsp_type duty_expected [$];
   int error_count = 0;
   int cycle_count = 0;
   bit calm = 1'b0;
   int gap_left = 0;
   int stall_left = 0;

   function automatic int quarter_sine(int unsigned k);
      longint unsigned x, x2, term;
      longint sum;
      x = (longint'(k) * PI_Q30) / 180;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      return int'((longint'(sum) + 32768) >>> 16);
   endfunction

   function automatic void build_sine_tab();
      int r, q;
      for (int k = 0; k < ANGLE_STEPS; k++) begin
         q = (k / QUARTER_STEPS) % 4;
         r = k % QUARTER_STEPS;
         case (q)
            0: sine_tab[k] = 16'(quarter_sine(r));
            1: sine_tab[k] = 16'(quarter_sine(QUARTER_STEPS - r));
            2: sine_tab[k] = 16'(-quarter_sine(r));
            default: sine_tab[k] = 16'(-quarter_sine(QUARTER_STEPS - r));
         endcase
      end
   endfunction

   function automatic int phase_to_duty(longint ph);
      longint q12, v;
      q12 = (ph + (64'sd1 <<< 29)) >>> 30;
      v = ((q12 * longint'(gain_cfg)) + 2048) >>> 12;
      v = v + center_cfg;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      if (v > max_cfg) v = max_cfg;
      if (v < min_cfg) v = min_cfg;
      return int'(v);
   endfunction

   function automatic rsp_type predict_duty(req_type it);
      rsp_type res;
      longint d, q, s, c, alpha, beta;
      int a, du, dv, dw, best;
      d = longint'(it.v_d);
      q = longint'(it.v_q);
      a = int'(it.angle_deg);
      a = a % ANGLE_STEPS;
      if (a < 0) a = a + ANGLE_STEPS;
      s = longint'(sine_tab[a]);
      c = longint'(sine_tab[(a + QUARTER_STEPS) % ANGLE_STEPS]);
      alpha = d * c - q * s;
      beta = d * s + q * c;
      du = phase_to_duty(alpha * 65536);
      dv = phase_to_duty(-alpha * 32768 + SQRT3_HALF_Q16 * beta);
      dw = phase_to_duty(-alpha * 32768 - SQRT3_HALF_Q16 * beta);
      best = 0;
      if (du > best) begin
         best = du;
         peak_seen = PHASE_U;
      end
      if (dv > best) begin
         best = dv;
         peak_seen = PHASE_V;
      end
      if (dw > best) begin
         best = dw;
         peak_seen = PHASE_W;
      end
      res.duty_u = 16'(du);
      res.duty_v = 16'(dv);
      res.duty_w = 16'(dw);
      res.peak_phase = peak_seen;
      return res;
   endfunction

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) duty_expected.push_back(predict_duty(req_data));
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (req_pending.size() > 0) begin
            req_data <= req_pending.pop_front();
            req_valid <= 1'b1;
            gap_left <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (duty_expected.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = duty_expected.pop_front();
            check_field("duty_u", int'(exp_rsp.duty_u), int'(rsp_data.duty_u));
            check_field("duty_v", int'(exp_rsp.duty_v), int'(rsp_data.duty_v));
            check_field("duty_w", int'(exp_rsp.duty_w), int'(rsp_data.duty_w));
            check_field("peak_phase", int'(exp_rsp.peak_phase),
                        int'(rsp_data.peak_phase));
         end
         n = draw_gap();
         stall_left <= n;
         rsp_stall <= (n != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 16'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PWM_GAIN: gain_cfg = val & 16'hFFFF;
         CSR_PWM_CENTER: center_cfg = val & 16'hFFFF;
         CSR_PWM_MIN: min_cfg = val & 16'hFFFF;
         CSR_PWM_MAX: max_cfg = val & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_pwm(input int g, input int c, input int mn, input int mx);
      csr_write(CSR_PWM_GAIN, g);
      csr_write(CSR_PWM_CENTER, c);
      csr_write(CSR_PWM_MIN, mn);
      csr_write(CSR_PWM_MAX, mx);
   endtask

   task automatic push_item(input int d, input int q, input int a);
      req_type it;
      it.v_d = 16'(d);
      it.v_q = 16'(q);
      it.angle_deg = 12'(a);
      req_pending.push_back(it);
   endtask

   task automatic push_random(input int count);
      req_type it;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 9);
         it.v_d = 16'($urandom);
         it.v_q = 16'($urandom);
         if (r < 4) begin
            it.v_d = 16'(int'($urandom_range(0, 8191)) - 4096);
            it.v_q = 16'(int'($urandom_range(0, 8191)) - 4096);
         end
         if (r == 9) it.angle_deg = 12'($urandom);
         else it.angle_deg = 12'(int'($urandom_range(0, 1439)) - 360);
         req_pending.push_back(it);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (req_pending.size() != 0 || req_valid || duty_expected.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int mn, mx;
      build_sine_tab();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes, wrap, ties
      push_item(0, 0, 0);
      push_item(32767, 0, 0);
      push_item(-32768, 0, 0);
      push_item(0, 32767, 90);
      push_item(0, -32768, 90);
      push_item(32767, 32767, 45);
      push_item(-32768, -32768, 225);
      push_item(32767, -32768, 359);
      push_item(-32768, 32767, -1);
      push_item(16384, 0, 120);
      push_item(16384, 0, 240);
      push_item(4096, 4096, -360);
      push_item(4096, 0, 1079);
      push_item(4096, 0, -2048);
      push_item(4096, 0, 2047);
      push_item(8192, -8192, 360);
      push_item(-4096, 4096, 180);
      push_item(2048, 0, 270);
      push_random(100);
      wait_drained();

      // saturation at zero and at the top
      set_pwm(65535, 0, 0, 65535);
      push_item(32767, 32767, 0);
      push_item(-32768, -32768, 0);
      push_item(32767, 0, 180);
      push_item(0, 0, 0);
      push_random(60);
      wait_drained();

      calm = 1'b1;
      csr_write(CSR_PWM_CENTER, 65535);
      push_random(60);
      wait_drained();

      // all compares zero: peak holds
      calm = 1'b0;
      set_pwm(500, 2048, 0, 0);
      csr_write(CSR_UNUSED, 16'hFFFF);
      push_random(30);
      wait_drained();

      // floor above ceiling
      set_pwm(1234, 2048, 3000, 1000);
      push_random(40);
      wait_drained();

      set_pwm(0, 0, 0, 65535);
      push_random(20);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         calm = (p == 2);
         mn = $urandom_range(0, 1000);
         mx = (p == 4) ? 65535 : $urandom_range(2000, 8000);
         set_pwm($urandom_range(0, 65535), $urandom_range(0, 8191), mn, mx);
         push_random(50);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
